FILE: rtl/pixel_tonemap_rational_core_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef PIXEL_TONEMAP_RATIONAL_CORE_MACROS_SVH
`define PIXEL_TONEMAP_RATIONAL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tonemap check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tonemap check failed");

`endif

FILE: rtl/trc_pkg.sv
package trc_pkg;

    localparam int CHANNEL_BITS = 32;
    localparam int COEF_BITS    = 32;
    localparam int LUMA_SHIFT   = 16;
    localparam int LUMA_W_BITS  = 16;
    localparam logic [LUMA_W_BITS-1:0] LUMA_R = 16'd13933;
    localparam logic [LUMA_W_BITS-1:0] LUMA_G = 16'd46871;
    localparam logic [LUMA_W_BITS-1:0] LUMA_B = 16'd4732;
    localparam int LANES = 3;

    typedef enum logic [2:0] {
        CFG_MODE       = 3'd0,
        CFG_NUM_SQUARE = 3'd1,
        CFG_NUM_LINEAR = 3'd2,
        CFG_NUM_CONST  = 3'd3,
        CFG_DEN_SQUARE = 3'd4,
        CFG_DEN_LINEAR = 3'd5,
        CFG_DEN_CONST  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] num_square;
        logic signed [COEF_BITS-1:0] num_linear;
        logic signed [COEF_BITS-1:0] num_const;
        logic signed [COEF_BITS-1:0] den_square;
        logic signed [COEF_BITS-1:0] den_linear;
        logic signed [COEF_BITS-1:0] den_const;
    } coef_set_t;

    localparam coef_set_t COEF_RESET = '{
        num_square: 32'sd59218,
        num_linear: 32'sd1180,
        num_const:  32'sd0,
        den_square: 32'sd57331,
        den_linear: 32'sd23200,
        den_const:  32'sd9175
    };

    typedef struct packed {
        logic bad;
        logic zero;
        logic sat;
    } lane_flags_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
        logic                    bad_denominator;
    } result_t;

endpackage

FILE: rtl/trc_div.sv
module trc_div #(
    parameter int QB = 32,
    parameter int DW = 146
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [DW-1:0]        dividend,
    input  logic [DW-1:0]        divisor,
    input  trc_pkg::lane_flags_t flags_in,
    output logic [QB-1:0]        quotient,
    output trc_pkg::lane_flags_t flags_out
);
    import trc_pkg::*;

    logic [DW-1:0] rem_reg [QB+1];
    logic [DW-1:0] den_reg [QB+1];
    logic [QB-1:0] quo_reg [QB+1];
    lane_flags_t   flg_reg [QB+1];
    lane_flags_t   flg_next;

    always_comb
    begin
        flg_next     = flags_in;
        flg_next.sat = (dividend >= (divisor << QB));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= dividend;
            den_reg[0] <= divisor;
            quo_reg[0] <= '0;
            flg_reg[0] <= flg_next;
        end
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_step
        logic [DW-1:0] trial;
        logic          ge;
        assign trial = den_reg[i] << (QB - 1 - i);
        assign ge    = (rem_reg[i] >= trial);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? (rem_reg[i] - trial) : rem_reg[i];
                den_reg[i+1] <= den_reg[i];
                quo_reg[i+1] <= quo_reg[i] | (QB'(ge) << (QB - 1 - i));
                flg_reg[i+1] <= flg_reg[i];
            end
        end
    end

    assign quotient  = quo_reg[QB];
    assign flags_out = flg_reg[QB];

endmodule

FILE: rtl/trc_luma.sv
module trc_luma (
    input  logic                              clk,
    input  logic                              en,
    input  trc_pkg::pixel_t                   pixel,
    output logic [trc_pkg::CHANNEL_BITS-1:0]  luma
);
    import trc_pkg::*;

    localparam int PB = CHANNEL_BITS + LUMA_W_BITS;

    logic [PB-1:0]           pr_reg, pg_reg, pb_reg;
    logic [PB+1:0]           sum;
    logic [CHANNEL_BITS-1:0] lum_reg, lum_d_reg;

    assign sum = (PB+2)'(pr_reg) + (PB+2)'(pg_reg) + (PB+2)'(pb_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg    <= PB'(pixel.red_in) * PB'(LUMA_R);
            pg_reg    <= PB'(pixel.green_in) * PB'(LUMA_G);
            pb_reg    <= PB'(pixel.blue_in) * PB'(LUMA_B);
            lum_reg   <= sum[LUMA_SHIFT +: CHANNEL_BITS];
            lum_d_reg <= lum_reg;
        end
    end

    assign luma = lum_d_reg;

endmodule

FILE: rtl/trc_lane.sv
module trc_lane #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic                              mode,
    input  trc_pkg::coef_set_t                coef,
    input  logic [trc_pkg::CHANNEL_BITS-1:0]  chan,
    input  logic [trc_pkg::CHANNEL_BITS-1:0]  luma,
    output logic [trc_pkg::CHANNEL_BITS-1:0]  value,
    output logic                              bad
);
    import trc_pkg::*;

    localparam int C  = CHANNEL_BITS;
    localparam int PW = COEF_BITS + C + 1;
    localparam int SW = 2 * C + 34;
    localparam int DW = 3 * C + FRACTION_BITS + 34;

    function automatic logic signed [SW-1:0] poly_sum(
        input logic signed [PW-1:0]        lo,
        input logic signed [PW-1:0]        hi,
        input logic signed [PW-1:0]        lin,
        input logic signed [COEF_BITS-1:0] cst
    );
        logic signed [SW-1:0] t_lo, t_hi, t_lin, t_cst;
        t_lo  = lo;
        t_hi  = hi;
        t_lin = lin;
        t_cst = cst;
        return (t_hi <<< C) + t_lo + (t_lin <<< FRACTION_BITS)
            + (t_cst <<< (2 * FRACTION_BITS));
    endfunction

    logic [C-1:0]          c1_reg, c2c_reg, c3_reg;
    logic [2*C-1:0]        sq_reg;
    logic signed [PW-1:0]  na_lo_reg, na_hi_reg, nb_reg;
    logic signed [PW-1:0]  da_lo_reg, da_hi_reg, db_reg;
    logic signed [SW-1:0]  num, den;
    logic [DW-1:0]         div_n, div_d, q_full;
    lane_flags_t           flg, flg_out;
    logic [C-1:0]          quo;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg    <= chan;
            sq_reg    <= (2*C)'(c1_reg) * (2*C)'(c1_reg);
            c2c_reg   <= c1_reg;
            na_lo_reg <= coef.num_square * $signed({1'b0, sq_reg[C-1:0]});
            na_hi_reg <= coef.num_square * $signed({1'b0, sq_reg[2*C-1:C]});
            nb_reg    <= coef.num_linear * $signed({1'b0, c2c_reg});
            da_lo_reg <= coef.den_square * $signed({1'b0, sq_reg[C-1:0]});
            da_hi_reg <= coef.den_square * $signed({1'b0, sq_reg[2*C-1:C]});
            db_reg    <= coef.den_linear * $signed({1'b0, c2c_reg});
            c3_reg    <= c2c_reg;
        end
    end

    always_comb
    begin
        num   = poly_sum(na_lo_reg, na_hi_reg, nb_reg, coef.num_const);
        den   = poly_sum(da_lo_reg, da_hi_reg, db_reg, coef.den_const);
        flg   = '0;
        if (mode)
        begin
            div_n = DW'(c3_reg) << FRACTION_BITS;
            div_d = (DW'(1) << FRACTION_BITS) + DW'(luma);
        end
        else
        begin
            flg.bad  = den[SW-1] || (den == '0);
            flg.zero = !flg.bad && (num[SW-1] || (num == '0));
            div_n    = DW'(num[SW-2:0]) << FRACTION_BITS;
            div_d    = DW'(den[SW-2:0]);
        end
    end

    trc_div #(
        .QB (C),
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .en        (en),
        .dividend  (div_n),
        .divisor   (div_d),
        .flags_in  (flg),
        .quotient  (quo),
        .flags_out (flg_out)
    );

    assign q_full = DW'(quo);
    assign bad    = flg_out.bad;

    always_comb
    begin
        if (flg_out.bad)
            value = '1;
        else if (flg_out.zero)
            value = '0;
        else if (flg_out.sat)
            value = '1;
        else
            value = q_full[C-1:0];
    end

endmodule

FILE: rtl/pixel_tonemap_rational_core.sv
// Throughput: one pixel per cycle unless pixel_stall is high; each lane runs three input and
// multiply stages, a divider input register and one divider stage per quotient bit.
// A two-entry output buffer lets the pipeline keep moving for one stalled result.
// Reset clears the valid pipeline and the output buffer valid flags, and loads the default curve.
module pixel_tonemap_rational_core #(
    parameter int FRACTION_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  trc_pkg::pixel_t  pixel,
    output logic             result_valid,
    input  logic             result_stall,
    output trc_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    import trc_pkg::*;
    `include "pixel_tonemap_rational_core_macros.svh"

    localparam int DEPTH = CHANNEL_BITS + 4;

    logic                    mode_reg;
    coef_set_t               coef_reg;
    logic [DEPTH-1:0]        vld_reg;
    logic                    en;
    logic [CHANNEL_BITS-1:0] luma;
    logic [CHANNEL_BITS-1:0] lane_in  [LANES];
    logic [CHANNEL_BITS-1:0] lane_val [LANES];
    logic [LANES-1:0]        lane_bad;
    result_t                 merged;
    result_t                 out_reg, skid_reg;
    logic                    out_vld_reg, skid_vld_reg;
    logic                    incoming;

    assign cfg_ready   = 1'b1;
    assign en          = !skid_vld_reg;
    assign pixel_stall = !en;
    assign incoming    = en && vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            coef_reg <= COEF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODE:       mode_reg            <= cfg_data[0];
                CFG_NUM_SQUARE: coef_reg.num_square <= cfg_data;
                CFG_NUM_LINEAR: coef_reg.num_linear <= cfg_data;
                CFG_NUM_CONST:  coef_reg.num_const  <= cfg_data;
                CFG_DEN_SQUARE: coef_reg.den_square <= cfg_data;
                CFG_DEN_LINEAR: coef_reg.den_linear <= cfg_data;
                CFG_DEN_CONST:  coef_reg.den_const  <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], pixel_valid};
    end

    trc_luma u_luma (
        .clk   (clk),
        .en    (en),
        .pixel (pixel),
        .luma  (luma)
    );

    assign lane_in[0] = pixel.red_in;
    assign lane_in[1] = pixel.green_in;
    assign lane_in[2] = pixel.blue_in;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        trc_lane #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .clk   (clk),
            .en    (en),
            .mode  (mode_reg),
            .coef  (coef_reg),
            .chan  (lane_in[i]),
            .luma  (luma),
            .value (lane_val[i]),
            .bad   (lane_bad[i])
        );
    end

    always_comb
    begin
        merged.red_out         = lane_val[0];
        merged.green_out       = lane_val[1];
        merged.blue_out        = lane_val[2];
        merged.bad_denominator = |lane_bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_vld_reg && result_stall)
        begin
            if (incoming)
                skid_vld_reg <= 1'b1;
        end
        else if (skid_vld_reg)
        begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= incoming;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_vld_reg && result_stall)
        begin
            if (incoming)
                skid_reg <= merged;
        end
        else if (skid_vld_reg)
            out_reg <= skid_reg;
        else if (incoming)
            out_reg <= merged;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    `TRC_ASSERT_NOW(a_skid_needs_out, skid_vld_reg, out_vld_reg)
    `TRC_ASSERT_NOW(a_skid_blocks_input, skid_vld_reg, pixel_stall)
    `TRC_ASSERT_NEXT(a_skid_drains, skid_vld_reg && !result_stall, !skid_vld_reg && out_vld_reg)

endmodule
